// ===== rtl/core/bnh_pkg.sv =====
// Package for the bounded neighbor heap: command codes, field widths,
// parameter defaults and the empty-slot weight constant. No dependencies.
`timescale 1ns / 1ps
package bnh_pkg;
    localparam int ROWS_DEF       = 1024;
    localparam int K_DEF          = 16;
    localparam int INDEX_BITS_DEF = 20;

    localparam int CMD_W  = 2;
    localparam int ROW_W  = 10;
    localparam int SLOT_W = 4;
    localparam int WGT_W  = 32;

    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    localparam logic [WGT_W-1:0] WGT_EMPTY = '1;
endpackage

// ===== rtl/core/bnh_req_if.sv =====
// Request channel of the bounded neighbor heap: valid/ready and the request fields.
// Depends on bnh_pkg.
`timescale 1ns / 1ps
interface bnh_req_if #(
    parameter int INDEX_BITS = bnh_pkg::INDEX_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [bnh_pkg::CMD_W-1:0]    cmd;
    logic [bnh_pkg::ROW_W-1:0]    row;
    logic [bnh_pkg::SLOT_W-1:0]   slot;
    logic [bnh_pkg::WGT_W-1:0]    weight;
    logic [INDEX_BITS-1:0]        neighbor;
    logic                         new_mark;

    modport source(output valid, cmd, row, slot, weight, neighbor, new_mark, input ready);
    modport sink(input valid, cmd, row, slot, weight, neighbor, new_mark, output ready);
endinterface

// ===== rtl/core/bnh_rsp_if.sv =====
// Result channel of the bounded neighbor heap: valid/ready and the result fields.
// Depends on bnh_pkg.
`timescale 1ns / 1ps
interface bnh_rsp_if #(
    parameter int INDEX_BITS = bnh_pkg::INDEX_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         inserted;
    logic signed [INDEX_BITS:0]   out_neighbor;
    logic [bnh_pkg::WGT_W-1:0]    out_weight;
    logic                         out_mark;
    logic                         last;

    modport source(output valid, inserted, out_neighbor, out_weight, out_mark, last,
                   input ready);
    modport sink(input valid, inserted, out_neighbor, out_weight, out_mark, last,
                 output ready);
endinterface

// ===== rtl/core/bnh_mem.sv =====
// Slot store: one write port, one read port, read data registered.
// No dependencies.
`timescale 1ns / 1ps
module bnh_mem #(
    parameter int DEPTH = 16384,
    parameter int AW    = 14,
    parameter int DW    = 54
) (
    input  logic          i_clk,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [DW-1:0] i_wr_data,
    input  logic [AW-1:0] i_rd_addr,
    output logic [DW-1:0] o_rd_data
);
    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;
endmodule

// ===== rtl/core/bnh_ctrl.sv =====
// Sequencer of the bounded neighbor heap: clear pass, push with duplicate scan and
// sift-down, heapsort drain, slot read. Drives bnh_mem ports; depends on bnh_pkg.
`timescale 1ns / 1ps
module bnh_ctrl #(
    parameter int ROWS       = bnh_pkg::ROWS_DEF,
    parameter int K          = bnh_pkg::K_DEF,
    parameter int INDEX_BITS = bnh_pkg::INDEX_BITS_DEF,
    parameter int AW         = $clog2(ROWS * K),
    parameter int DW         = INDEX_BITS + 34
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    bnh_req_if.sink       i_req,
    bnh_rsp_if.source     o_rsp,
    output logic          o_wr_en,
    output logic [AW-1:0] o_wr_addr,
    output logic [DW-1:0] o_wr_data,
    output logic [AW-1:0] o_rd_addr,
    input  logic [DW-1:0] i_rd_data
);
    localparam int NW    = INDEX_BITS + 1;
    localparam int CW    = $clog2(K);
    localparam int LW    = CW + 2;
    localparam int DEPTH = ROWS * K;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [LW-1:0] K_L       = LW'(K);
    localparam logic [CW-1:0] K_LAST    = CW'(K - 1);
    localparam logic [DW-1:0] EMPTY     = {1'b0, {NW{1'b1}}, bnh_pkg::WGT_EMPTY};

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_OUT   = 5'd2;
    localparam logic [4:0] S_P_RT  = 5'd3;
    localparam logic [4:0] S_P_CHK = 5'd4;
    localparam logic [4:0] S_P_SCN = 5'd5;
    localparam logic [4:0] S_P_SFT = 5'd6;
    localparam logic [4:0] S_P_C1  = 5'd7;
    localparam logic [4:0] S_P_C2  = 5'd8;
    localparam logic [4:0] S_H_RT  = 5'd9;
    localparam logic [4:0] S_H_END = 5'd10;
    localparam logic [4:0] S_H_SWP = 5'd11;
    localparam logic [4:0] S_H_SFT = 5'd12;
    localparam logic [4:0] S_H_L   = 5'd13;
    localparam logic [4:0] S_H_R   = 5'd14;
    localparam logic [4:0] S_D_RD  = 5'd15;
    localparam logic [4:0] S_D_LD  = 5'd16;
    localparam logic [4:0] S_R_RD  = 5'd17;
    localparam logic [4:0] S_R_LD  = 5'd18;

    logic [4:0]          r_state, n_state;
    logic [AW-1:0]       r_clr, n_clr;
    logic [AW-1:0]       r_base, n_base;
    logic [bnh_pkg::CMD_W-1:0] r_cmd, n_cmd;
    logic                r_row_ok, n_row_ok;
    logic [CW-1:0]       r_slot, n_slot;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]       r_pos, n_pos;
    logic [CW-1:0]       r_end, n_end;
    logic [DW-1:0]       r_elem, n_elem;
    logic [DW-1:0]       r_top, n_top;
    logic [DW-1:0]       r_c1, n_c1;
    logic                r_o_valid, n_o_valid;
    logic                r_o_ins, n_o_ins;
    logic [NW-1:0]       r_o_nb, n_o_nb;
    logic [bnh_pkg::WGT_W-1:0] r_o_w, n_o_w;
    logic                r_o_mark, n_o_mark;
    logic                r_o_last, n_o_last;

    logic                acc;
    logic                row_ok, slot_ok;
    logic [LW-1:0]       lc, rc;
    logic [DW-1:0]       pick;
    logic [CW-1:0]       pick_pos;
    logic                pick_move;

    assign acc     = i_req.valid && i_req.ready;
    assign row_ok  = 32'(i_req.row) < ROWS;
    assign slot_ok = 32'(i_req.slot) < K;
    assign lc      = {1'b0, r_pos, 1'b1};
    assign rc      = lc + LW'(1);

    // heapsort choice among element, left child (r_c1) and right child (i_rd_data)
    always_comb begin
        pick      = r_elem;
        pick_pos  = r_pos;
        pick_move = 1'b0;
        if (r_elem[31:0] < r_c1[31:0]) begin
            pick      = r_c1;
            pick_pos  = CW'(lc);
            pick_move = 1'b1;
        end
        if (pick[31:0] < i_rd_data[31:0]) begin
            pick      = i_rd_data;
            pick_pos  = CW'(rc);
            pick_move = 1'b1;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_base    = r_base;
        n_cmd     = r_cmd;
        n_row_ok  = r_row_ok;
        n_slot    = r_slot;
        n_cnt     = r_cnt;
        n_pos     = r_pos;
        n_end     = r_end;
        n_elem    = r_elem;
        n_top     = r_top;
        n_c1      = r_c1;
        n_o_valid = r_o_valid;
        n_o_ins   = r_o_ins;
        n_o_nb    = r_o_nb;
        n_o_w     = r_o_w;
        n_o_mark  = r_o_mark;
        n_o_last  = r_o_last;
        o_wr_en   = 1'b0;
        o_wr_addr = r_base + AW'(r_pos);
        o_wr_data = r_elem;
        o_rd_addr = r_base;
        case (r_state)
            S_CLR: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_clr;
                o_wr_data = EMPTY;
                n_clr     = r_clr + AW'(1);
                if (r_clr == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (acc) begin
                    n_cmd    = i_req.cmd;
                    n_row_ok = row_ok;
                    n_slot   = CW'(i_req.slot);
                    n_base   = row_ok ? AW'(32'(i_req.row) * 32'(K)) : '0;
                    n_elem   = {i_req.new_mark, 1'b0, i_req.neighbor, i_req.weight};
                    n_cnt    = '0;
                    n_pos    = '0;
                    n_end    = K_LAST;
                    n_o_ins  = 1'b0;
                    n_o_nb   = '1;
                    n_o_w    = bnh_pkg::WGT_EMPTY;
                    n_o_mark = 1'b0;
                    n_o_last = 1'b1;
                    case (i_req.cmd)
                        bnh_pkg::CMD_PUSH: begin
                            n_o_nb = '0;
                            n_o_w  = '0;
                            if (row_ok) begin
                                n_state = S_P_RT;
                            end else begin
                                n_o_valid = 1'b1;
                                n_state   = S_OUT;
                            end
                        end
                        bnh_pkg::CMD_DRAIN: begin
                            if (row_ok) begin
                                n_state = S_H_RT;
                            end else begin
                                n_o_last  = 1'b0;
                                n_o_valid = 1'b1;
                                n_state   = S_OUT;
                            end
                        end
                        bnh_pkg::CMD_READ: begin
                            if (row_ok && slot_ok) begin
                                n_state = S_R_RD;
                            end else begin
                                n_o_valid = 1'b1;
                                n_state   = S_OUT;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_OUT: begin
                if (o_rsp.ready) begin
                    if (r_cmd == bnh_pkg::CMD_DRAIN && !r_o_last) begin
                        n_cnt = r_cnt + CW'(1);
                        if (r_row_ok) begin
                            n_o_valid = 1'b0;
                            n_state   = S_D_RD;
                        end else begin
                            n_o_last = (r_cnt + CW'(1)) == K_LAST;
                        end
                    end else begin
                        n_o_valid = 1'b0;
                        n_state   = S_IDLE;
                    end
                end
            end
            S_P_RT: begin
                n_state = S_P_CHK;
            end
            S_P_CHK: begin
                if (r_elem[31:0] >= i_rd_data[31:0]) begin
                    n_o_valid = 1'b1;
                    n_state   = S_OUT;
                end else begin
                    n_state = S_P_SCN;
                end
            end
            S_P_SCN: begin
                o_rd_addr = r_base + AW'(r_cnt) + AW'(1);
                if (i_rd_data[DW-2:32] == r_elem[DW-2:32]) begin
                    n_o_valid = 1'b1;
                    n_state   = S_OUT;
                end else if (r_cnt == K_LAST) begin
                    n_state = S_P_SFT;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_P_SFT: begin
                o_rd_addr = r_base + AW'(lc);
                if (lc >= K_L) begin
                    o_wr_en   = 1'b1;
                    n_o_ins   = 1'b1;
                    n_o_valid = 1'b1;
                    n_state   = S_OUT;
                end else begin
                    n_state = S_P_C1;
                end
            end
            S_P_C1: begin
                n_c1      = i_rd_data;
                o_rd_addr = r_base + AW'(rc);
                if (rc >= K_L) begin
                    o_wr_en = 1'b1;
                    if (i_rd_data[31:0] >= r_elem[31:0]) begin
                        o_wr_data = i_rd_data;
                        n_pos     = CW'(lc);
                        n_state   = S_P_SFT;
                    end else begin
                        n_o_ins   = 1'b1;
                        n_o_valid = 1'b1;
                        n_state   = S_OUT;
                    end
                end else begin
                    n_state = S_P_C2;
                end
            end
            S_P_C2: begin
                o_wr_en = 1'b1;
                if (r_c1[31:0] >= i_rd_data[31:0] && r_elem[31:0] < r_c1[31:0]) begin
                    o_wr_data = r_c1;
                    n_pos     = CW'(lc);
                    n_state   = S_P_SFT;
                end else if (r_c1[31:0] < i_rd_data[31:0]
                             && r_elem[31:0] < i_rd_data[31:0]) begin
                    o_wr_data = i_rd_data;
                    n_pos     = CW'(rc);
                    n_state   = S_P_SFT;
                end else begin
                    n_o_ins   = 1'b1;
                    n_o_valid = 1'b1;
                    n_state   = S_OUT;
                end
            end
            S_H_RT: begin
                n_state = S_H_END;
            end
            S_H_END: begin
                o_rd_addr = r_base + AW'(r_end);
                n_top     = i_rd_data;
                n_state   = S_H_SWP;
            end
            S_H_SWP: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_base + AW'(r_end);
                o_wr_data = r_top;
                n_elem    = i_rd_data;
                n_pos     = '0;
                n_state   = S_H_SFT;
            end
            S_H_SFT: begin
                o_rd_addr = r_base + AW'(lc);
                if (lc >= LW'(r_end)) begin
                    o_wr_en = 1'b1;
                    if (r_end == CW'(1)) begin
                        n_cnt   = '0;
                        n_state = S_D_RD;
                    end else begin
                        n_end   = r_end - CW'(1);
                        n_state = S_H_RT;
                    end
                end else begin
                    n_state = S_H_L;
                end
            end
            S_H_L: begin
                n_c1      = i_rd_data;
                o_rd_addr = r_base + AW'(rc);
                if (rc < LW'(r_end)) begin
                    n_state = S_H_R;
                end else if (r_elem[31:0] < i_rd_data[31:0]) begin
                    o_wr_en   = 1'b1;
                    o_wr_data = i_rd_data;
                    n_pos     = CW'(lc);
                    n_state   = S_H_SFT;
                end else begin
                    o_wr_en = 1'b1;
                    n_end   = r_end - CW'(1);
                    n_state = S_H_RT;
                end
            end
            S_H_R: begin
                o_wr_en = 1'b1;
                if (pick_move) begin
                    o_wr_data = pick;
                    n_pos     = pick_pos;
                    n_state   = S_H_SFT;
                end else begin
                    n_end   = r_end - CW'(1);
                    n_state = S_H_RT;
                end
            end
            S_D_RD: begin
                o_rd_addr = r_base + AW'(r_cnt);
                n_state   = S_D_LD;
            end
            S_D_LD: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_base + AW'(r_cnt);
                o_wr_data = EMPTY;
                n_o_nb    = i_rd_data[DW-2:32];
                n_o_w     = i_rd_data[31:0];
                n_o_mark  = i_rd_data[DW-1];
                n_o_last  = r_cnt == K_LAST;
                n_o_valid = 1'b1;
                n_state   = S_OUT;
            end
            S_R_RD: begin
                o_rd_addr = r_base + AW'(r_slot);
                n_state   = S_R_LD;
            end
            S_R_LD: begin
                o_wr_en   = 1'b1;
                o_wr_addr = r_base + AW'(r_slot);
                o_wr_data = {1'b0, i_rd_data[DW-2:0]};
                n_o_nb    = i_rd_data[DW-2:32];
                n_o_w     = i_rd_data[31:0];
                n_o_mark  = i_rd_data[DW-1];
                n_o_valid = 1'b1;
                n_state   = S_OUT;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLR;
            r_clr     <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_clr     <= n_clr;
            r_o_valid <= n_o_valid;
        end
        r_base   <= n_base;
        r_cmd    <= n_cmd;
        r_row_ok <= n_row_ok;
        r_slot   <= n_slot;
        r_cnt    <= n_cnt;
        r_pos    <= n_pos;
        r_end    <= n_end;
        r_elem   <= n_elem;
        r_top    <= n_top;
        r_c1     <= n_c1;
        r_o_ins  <= n_o_ins;
        r_o_nb   <= n_o_nb;
        r_o_w    <= n_o_w;
        r_o_mark <= n_o_mark;
        r_o_last <= n_o_last;
    end

    assign i_req.ready        = (r_state == S_IDLE);
    assign o_rsp.valid        = r_o_valid;
    assign o_rsp.inserted     = r_o_ins;
    assign o_rsp.out_neighbor = $signed(r_o_nb);
    assign o_rsp.out_weight   = r_o_w;
    assign o_rsp.out_mark     = r_o_mark;
    assign o_rsp.last         = r_o_last;

    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLR) |-> !i_req.ready)
        else $error("request taken during clear pass");
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && (i_req.cmd == bnh_pkg::CMD_PUSH || i_req.cmd == bnh_pkg::CMD_DRAIN
                 || i_req.cmd == bnh_pkg::CMD_READ)) |=> !i_req.ready)
        else $error("second request taken while busy");
    a_valid_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_state == S_OUT))
        else $error("result valid outside output state");
    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |-> (o_wr_addr <= LAST_ADDR))
        else $error("write beyond slot store");
endmodule

// ===== rtl/core/bounded_neighbor_heap.sv =====
// Bounded neighbor heap: ROWS max-heaps of K slots in one slot store.
// Read: one slot per request. Push: root check, duplicate scan one slot a cycle, then
// sift-down two reads a level. Drain: heapsort in the slot store, then K results, each
// read only after the previous one is taken.
// One request at a time; the slot store has a single read port.
// After reset a clear pass writes ROWS*K slots, one per cycle, before the first request.
`timescale 1ns / 1ps
module bounded_neighbor_heap #(
    parameter int ROWS       = bnh_pkg::ROWS_DEF,
    parameter int K          = bnh_pkg::K_DEF,
    parameter int INDEX_BITS = bnh_pkg::INDEX_BITS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bnh_req_if.sink   i_req,
    bnh_rsp_if.source o_rsp
);
    localparam int AW = $clog2(ROWS * K);
    localparam int DW = INDEX_BITS + 34;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [DW-1:0] wr_data;
    logic [AW-1:0] rd_addr;
    logic [DW-1:0] rd_data;

    bnh_mem #(
        .DEPTH(ROWS * K),
        .AW   (AW),
        .DW   (DW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    bnh_ctrl #(
        .ROWS      (ROWS),
        .K         (K),
        .INDEX_BITS(INDEX_BITS),
        .AW        (AW),
        .DW        (DW)
    ) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (i_req),
        .o_rsp    (o_rsp),
        .o_wr_en  (wr_en),
        .o_wr_addr(wr_addr),
        .o_wr_data(wr_data),
        .o_rd_addr(rd_addr),
        .i_rd_data(rd_data)
    );
endmodule

// ===== tb/tb_bounded_neighbor_heap.sv =====
// Self-checking testbench for bounded_neighbor_heap: push, drain and read requests
// against an in-bench heap predictor, with random idling on both channels.
// Depends on bnh_pkg, bnh_req_if, bnh_rsp_if and the RTL top level.
`timescale 1ns / 1ps
module tb_bounded_neighbor_heap;
    localparam int ROWS     = bnh_pkg::ROWS_DEF;
    localparam int K        = bnh_pkg::K_DEF;
    localparam int IDX_W    = bnh_pkg::INDEX_BITS_DEF;
    localparam int CMD_W    = bnh_pkg::CMD_W;
    localparam int ROW_W    = bnh_pkg::ROW_W;
    localparam int SLOT_W   = bnh_pkg::SLOT_W;
    localparam int WGT_W    = bnh_pkg::WGT_W;
    localparam int LIMIT    = 1000000;
    localparam logic signed [IDX_W:0] NB_EMPTY = -1;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]  cmd;
        logic [ROW_W-1:0]  row;
        logic [SLOT_W-1:0] slot;
        logic [WGT_W-1:0]  weight;
        logic [IDX_W-1:0]  nbr;
        logic              mark;
        bit                barrier;
    } t_heap_req;

    typedef struct {
        logic                    ins;
        logic signed [IDX_W:0]   nbr;
        logic [WGT_W-1:0]        w;
        logic                    mark;
        logic                    last;
    } t_heap_rsp;

    logic i_clk;
    logic i_rst_n;
    bnh_req_if #(.INDEX_BITS(IDX_W)) req_ch();
    bnh_rsp_if #(.INDEX_BITS(IDX_W)) rsp_ch();

    bounded_neighbor_heap #(.ROWS(ROWS), .K(K), .INDEX_BITS(IDX_W)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    logic [WGT_W-1:0]      dist_mem [ROWS*K];
    logic signed [IDX_W:0] nbr_mem  [ROWS*K];
    logic                  mark_mem [ROWS*K];

    t_heap_req pending_q[$];
    t_heap_rsp expected_q[$];
    int        errors = 0;
    int        accepted = 0;
    int        cycles = 0;
    bit        req_taken = 0;
    bit        running = 0;
    bit        hold = 0;
    int        gap = 0;
    int        stall = 0;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    task automatic add_expected(input t_heap_rsp r);
        expected_q.insert(expected_q.size(), r);
    endtask

    task automatic swap_slots(input int a, input int b);
        logic [WGT_W-1:0]      tw;
        logic signed [IDX_W:0] tn;
        logic                  tm;
        tw = dist_mem[a]; dist_mem[a] = dist_mem[b]; dist_mem[b] = tw;
        tn = nbr_mem[a];  nbr_mem[a]  = nbr_mem[b];  nbr_mem[b]  = tn;
        tm = mark_mem[a]; mark_mem[a] = mark_mem[b]; mark_mem[b] = tm;
    endtask

    task automatic sort_sift(input int base, input int len);
        int e;
        int l;
        int s;
        e = 0;
        while (e * 2 + 1 < len) begin
            l = e * 2 + 1;
            s = e;
            if (dist_mem[base+s] < dist_mem[base+l]) s = l;
            if (l + 1 < len && dist_mem[base+s] < dist_mem[base+l+1]) s = l + 1;
            if (s == e) break;
            swap_slots(base + e, base + s);
            e = s;
        end
    endtask

    function automatic t_heap_rsp mk_rsp(logic ins, logic signed [IDX_W:0] nb,
                                         logic [WGT_W-1:0] w, logic m, logic lst);
        t_heap_rsp r;
        r.ins = ins; r.nbr = nb; r.w = w; r.mark = m; r.last = lst;
        return r;
    endfunction

    task automatic push_entry(input t_heap_req rq);
        int  base;
        int  i;
        int  c1;
        int  sw;
        bit  ok;
        base = int'(rq.row) * K;
        ok = rq.weight < dist_mem[base];
        for (i = 0; i < K && ok; i++)
            if (nbr_mem[base+i] == $signed({1'b0, rq.nbr})) ok = 0;
        if (ok) begin
            i = 0;
            forever begin
                c1 = 2 * i + 1;
                if (c1 >= K) break;
                if (c1 + 1 >= K) begin
                    if (dist_mem[base+c1] >= rq.weight) sw = c1; else break;
                end else if (dist_mem[base+c1] >= dist_mem[base+c1+1]) begin
                    if (rq.weight < dist_mem[base+c1]) sw = c1; else break;
                end else begin
                    if (rq.weight < dist_mem[base+c1+1]) sw = c1 + 1; else break;
                end
                dist_mem[base+i] = dist_mem[base+sw];
                nbr_mem[base+i]  = nbr_mem[base+sw];
                mark_mem[base+i] = mark_mem[base+sw];
                i = sw;
            end
            dist_mem[base+i] = rq.weight;
            nbr_mem[base+i]  = $signed({1'b0, rq.nbr});
            mark_mem[base+i] = rq.mark;
        end
        add_expected(mk_rsp(ok, '0, '0, 1'b0, 1'b1));
    endtask

    task automatic predict_request(input t_heap_req rq);
        int base;
        int j;
        base = int'(rq.row) * K;
        case (rq.cmd)
            bnh_pkg::CMD_PUSH: push_entry(rq);
            bnh_pkg::CMD_DRAIN: begin
                for (j = 0; j + 1 < K; j++) begin
                    swap_slots(base, base + K - j - 1);
                    sort_sift(base, K - j - 1);
                end
                for (j = 0; j < K; j++) begin
                    add_expected(mk_rsp(1'b0, nbr_mem[base+j], dist_mem[base+j],
                                        mark_mem[base+j], j == K - 1));
                    dist_mem[base+j] = bnh_pkg::WGT_EMPTY;
                    nbr_mem[base+j]  = NB_EMPTY;
                    mark_mem[base+j] = 1'b0;
                end
            end
            bnh_pkg::CMD_READ: begin
                j = base + int'(rq.slot);
                add_expected(mk_rsp(1'b0, nbr_mem[j], dist_mem[j], mark_mem[j], 1'b1));
                mark_mem[j] = 1'b0;
            end
            default: ;
        endcase
    endtask

    // predict on acceptance, then check results
    always @(posedge i_clk) begin
        t_heap_rsp exp_r;
        t_heap_req rq;
        cycles++;
        req_taken <= req_ch.valid && req_ch.ready;
        if (i_rst_n && req_ch.valid && req_ch.ready) begin
            rq.cmd = req_ch.cmd; rq.row = req_ch.row; rq.slot = req_ch.slot;
            rq.weight = req_ch.weight; rq.nbr = req_ch.neighbor; rq.mark = req_ch.new_mark;
            rq.barrier = 0;
            predict_request(rq);
            accepted++;
        end
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result at cycle %0d", cycles);
            end else begin
                exp_r = expected_q.pop_front();
                if (rsp_ch.inserted !== exp_r.ins || rsp_ch.out_neighbor !== exp_r.nbr ||
                    rsp_ch.out_weight !== exp_r.w || rsp_ch.out_mark !== exp_r.mark ||
                    rsp_ch.last !== exp_r.last) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("cycle %0d exp ins=%b nb=%0d w=%h m=%b l=%b",
                                 cycles, exp_r.ins, exp_r.nbr, exp_r.w, exp_r.mark,
                                 exp_r.last);
                        $display("    got ins=%b nb=%0d w=%h m=%b l=%b",
                                 rsp_ch.inserted, rsp_ch.out_neighbor, rsp_ch.out_weight,
                                 rsp_ch.out_mark, rsp_ch.last);
                    end
                end
            end
        end
        if (cycles > LIMIT) begin
            $display("bounded_neighbor_heap: mismatch");
            $finish;
        end
    end

    // request driver
    always @(negedge i_clk) begin
        t_heap_req rq;
        if (running && !(req_ch.valid && !req_taken)) begin
            if (gap > 0) begin
                gap--;
                req_ch.valid <= 1'b0;
            end else if (pending_q.size() == 0) begin
                req_ch.valid <= 1'b0;
            end else if (pending_q[0].barrier) begin
                if (expected_q.size() == 0) void'(pending_q.pop_front());
                req_ch.valid <= 1'b0;
            end else if (pending_q.size() > 40 && $urandom_range(0, 9) == 0) begin
                gap = $urandom_range(0, 17);
                req_ch.valid <= 1'b0;
            end else begin
                rq = pending_q.pop_front();
                req_ch.valid    <= 1'b1;
                req_ch.cmd      <= rq.cmd;
                req_ch.row      <= rq.row;
                req_ch.slot     <= rq.slot;
                req_ch.weight   <= rq.weight;
                req_ch.neighbor <= rq.nbr;
                req_ch.new_mark <= rq.mark;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (running) begin
            if (hold) begin
                rsp_ch.ready <= 1'b0;
            end else if (stall > 0) begin
                stall--;
                rsp_ch.ready <= 1'b0;
            end else if (pending_q.size() > 40 && $urandom_range(0, 7) == 0) begin
                stall = $urandom_range(0, 17);
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off so the block backs up
    initial begin
        wait (accepted >= 100);
        hold = 1;
        repeat (600) @(posedge i_clk);
        hold = 0;
    end

    task automatic add_req(input logic [CMD_W-1:0] c, input logic [ROW_W-1:0] r,
                           input logic [SLOT_W-1:0] s, input logic [WGT_W-1:0] w,
                           input logic [IDX_W-1:0] n, input logic m);
        t_heap_req rq;
        rq.cmd = c; rq.row = r; rq.slot = s; rq.weight = w; rq.nbr = n; rq.mark = m;
        rq.barrier = 0;
        pending_q.insert(pending_q.size(), rq);
    endtask

    task automatic add_barrier();
        t_heap_req rq;
        rq = '{default: '0};
        rq.barrier = 1;
        pending_q.insert(pending_q.size(), rq);
    endtask

    task automatic add_random();
        logic [CMD_W-1:0]  c;
        logic [ROW_W-1:0]  r;
        logic [WGT_W-1:0]  w;
        logic [IDX_W-1:0]  n;
        int                pick;
        pick = $urandom_range(0, 99);
        if (pick < 68) c = bnh_pkg::CMD_PUSH;
        else if (pick < 88) c = bnh_pkg::CMD_READ;
        else if (pick < 96) c = bnh_pkg::CMD_DRAIN;
        else c = CMD_UNUSED;
        pick = $urandom_range(0, 9);
        r = (pick < 8) ? ROW_W'($urandom_range(0, 5)) :
            (pick == 8) ? ROW_W'(ROWS - 1) : ROW_W'($urandom);
        pick = $urandom_range(0, 9);
        w = (pick < 6) ? WGT_W'($urandom_range(0, 300)) :
            (pick < 9) ? WGT_W'($urandom) : bnh_pkg::WGT_EMPTY;
        n = ($urandom_range(0, 3) != 0) ? IDX_W'($urandom_range(0, 40)) : IDX_W'($urandom);
        add_req(c, r, SLOT_W'($urandom), w, n, 1'($urandom));
    endtask

    initial begin
        int i;
        i_rst_n = 1'b0;
        req_ch.valid = 1'b0; req_ch.cmd = '0; req_ch.row = '0; req_ch.slot = '0;
        req_ch.weight = '0; req_ch.neighbor = '0; req_ch.new_mark = 1'b0;
        rsp_ch.ready = 1'b0;
        for (i = 0; i < ROWS * K; i++) begin
            dist_mem[i] = bnh_pkg::WGT_EMPTY; nbr_mem[i] = NB_EMPTY; mark_mem[i] = 1'b0;
        end

        add_req(bnh_pkg::CMD_PUSH, 0, 0, 100, 5, 1);
        add_req(bnh_pkg::CMD_PUSH, 0, 0, 50, 5, 0);
        add_req(bnh_pkg::CMD_PUSH, 0, 0, bnh_pkg::WGT_EMPTY, 6, 1);
        add_req(bnh_pkg::CMD_PUSH, 0, 0, 0, '1, 1);
        add_req(bnh_pkg::CMD_PUSH, 0, 0, 32'hFFFF_FFFE, 7, 1);
        add_req(bnh_pkg::CMD_READ, 0, 0, 0, 0, 0);
        add_req(bnh_pkg::CMD_READ, 0, 0, 0, 0, 0);
        add_req(bnh_pkg::CMD_READ, 0, '1, 0, 0, 0);
        add_req(CMD_UNUSED, 0, 0, 0, 0, 0);
        add_req(bnh_pkg::CMD_DRAIN, 0, 0, 0, 0, 0);
        add_req(bnh_pkg::CMD_DRAIN, '1, 0, 0, 0, 0);
        for (i = 0; i < 17; i++)
            add_req(bnh_pkg::CMD_PUSH, '1, 0, WGT_W'(1000 - i * 10), IDX_W'(i), 1);
        add_req(bnh_pkg::CMD_PUSH, '1, 0, 850, 99, 0);
        add_req(bnh_pkg::CMD_READ, '1, '1, 0, 0, 0);
        add_req(bnh_pkg::CMD_DRAIN, '1, 0, 0, 0, 0);
        add_barrier();
        for (i = 0; i < 320; i++) begin
            add_random();
            if (i == 200) add_barrier();
        end

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        running = 1;
        while (pending_q.size() != 0 || req_ch.valid) @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (errors == 0 && expected_q.size() == 0)
            $display("bounded_neighbor_heap: match");
        else
            $display("bounded_neighbor_heap: mismatch");
        $finish;
    end
endmodule

// ===== filelist.f =====
rtl/core/bnh_pkg.sv
rtl/core/bnh_req_if.sv
rtl/core/bnh_rsp_if.sv
rtl/core/bnh_mem.sv
rtl/core/bnh_ctrl.sv
rtl/core/bounded_neighbor_heap.sv
tb/tb_bounded_neighbor_heap.sv
